>>> design/ps2mt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; imported by ps2_mouse_packet_tracker_core.
package ps2mt_pkg;

    typedef enum logic [1:0] {
        PH_HEAD   = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } t_phase;

    localparam logic [7:0] ACK_BYTE   = 8'hFA;
    localparam int         X_SIGN_BIT = 4;
    localparam int         Y_SIGN_BIT = 5;

    localparam int CFG_W       = 13;
    localparam int OUT_COORD_W = 12;
    localparam int IDX_W       = 24;
    localparam int BTN_W       = 3;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic EV_MOVE = 1'b0;
    localparam logic EV_ACK  = 1'b1;

endpackage

>>> design/ps2_mouse_packet_tracker_core.sv
// PS/2 mouse packet tracker: frames mouse bytes into 3-byte packets, tracks a
// clamped cursor and reports movement and acknowledge requests.
// Depends on ps2mt_pkg.
//
// Accepts one byte per cycle for as long as the result side keeps up. A byte
// that completes a packet, or an acknowledge byte (0xFA at packet start),
// yields one result: the first stage register takes the updated cursor (add
// and clamp), the result register then takes the pixel index (one multiply
// by the screen width). The first two bytes of a packet yield no result.
// Screen width and height are APB registers at byte addresses 0 and 4; a value
// of 0 acts as 1 and a value above 2**COORD_BITS acts as 2**COORD_BITS.
// Cursor fields carry the low 12 bits of the position, the index the low 24.
module ps2_mouse_packet_tracker_core
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,

    input  logic                      i_rx_valid,
    output logic                      o_rx_stall,
    input  logic [7:0]                i_rx_byte,

    output logic                      o_ev_valid,
    input  logic                      i_ev_stall,
    output logic                      o_event_kind,
    output logic [OUT_COORD_W-1:0]    o_cursor_x,
    output logic [OUT_COORD_W-1:0]    o_cursor_y,
    output logic [BTN_W-1:0]          o_buttons,
    output logic [BTN_W-1:0]          o_buttons_changed,
    output logic                      o_draw,
    output logic [IDX_W-1:0]          o_pixel_index
);

    localparam int SW = COORD_BITS + 1;
    localparam int VW = COORD_BITS + 2;
    localparam int PW = 2 * COORD_BITS + 2;

    logic [CFG_W-1:0]      r_width;
    logic [CFG_W-1:0]      r_height;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [7:0]            r_header;
    logic [7:0]            n_header;
    logic [7:0]            r_xbyte;
    logic [7:0]            n_xbyte;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] n_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic [COORD_BITS-1:0] n_pos_y;
    logic [BTN_W-1:0]      r_last_btn;
    logic [BTN_W-1:0]      n_last_btn;

    logic                  r_s1_valid;
    logic                  n_s1_valid;
    logic                  r_s1_kind;
    logic                  n_s1_kind;
    logic [COORD_BITS-1:0] r_s1_x;
    logic [COORD_BITS-1:0] n_s1_x;
    logic [COORD_BITS-1:0] r_s1_y;
    logic [COORD_BITS-1:0] n_s1_y;
    logic [BTN_W-1:0]      r_s1_btn;
    logic [BTN_W-1:0]      n_s1_btn;
    logic [BTN_W-1:0]      r_s1_chg;
    logic [BTN_W-1:0]      n_s1_chg;
    logic [SW-1:0]         r_s1_w;
    logic [SW-1:0]         n_s1_w;

    logic                  r_ev_valid;
    logic                  r_ev_kind;
    logic [OUT_COORD_W-1:0] r_ev_x;
    logic [OUT_COORD_W-1:0] r_ev_y;
    logic [BTN_W-1:0]      r_ev_btn;
    logic [BTN_W-1:0]      r_ev_chg;
    logic                  r_ev_draw;
    logic [IDX_W-1:0]      r_ev_idx;

    logic                  rx_fire;
    logic                  s1_load;
    logic                  s2_load;
    logic                  cfg_write;
    logic                  is_ack;
    logic                  has_result;

    logic [31:0]           lim;
    logic [SW-1:0]         eff_w;
    logic [SW-1:0]         eff_h;
    logic signed [8:0]     dx;
    logic signed [8:0]     dy;
    logic signed [VW-1:0]  sum_x;
    logic signed [VW-1:0]  sum_y;
    logic [COORD_BITS-1:0] clamp_x;
    logic [COORD_BITS-1:0] clamp_y;
    logic [BTN_W-1:0]      pkt_btn;

    logic [PW-1:0]             idx_full;
    logic [PW+IDX_W-1:0]       idx_ext;
    logic [COORD_BITS+OUT_COORD_W-1:0] x_ext;
    logic [COORD_BITS+OUT_COORD_W-1:0] y_ext;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_SCREEN_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_SCREEN_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign s2_load    = r_s1_valid && (!r_ev_valid || !i_ev_stall);
    assign s1_load    = !r_s1_valid || s2_load;
    assign o_rx_stall = !s1_load;
    assign rx_fire    = i_rx_valid && s1_load;

    // effective screen size
    always_comb begin
        lim = 32'd1 << COORD_BITS;
        if (r_width == '0)
            eff_w = SW'(1);
        else if (32'(r_width) > lim)
            eff_w = SW'(lim);
        else
            eff_w = SW'(r_width);
        if (r_height == '0)
            eff_h = SW'(1);
        else if (32'(r_height) > lim)
            eff_h = SW'(lim);
        else
            eff_h = SW'(r_height);
    end

    // cursor update
    always_comb begin
        dx      = $signed({r_header[X_SIGN_BIT], r_xbyte});
        dy      = $signed({r_header[Y_SIGN_BIT], i_rx_byte});
        sum_x   = $signed({2'b00, r_pos_x}) + VW'(dx);
        sum_y   = $signed({2'b00, r_pos_y}) - VW'(dy);
        if (sum_x < 0)
            clamp_x = '0;
        else if (sum_x >= $signed({1'b0, eff_w}))
            clamp_x = COORD_BITS'(eff_w - SW'(1));
        else
            clamp_x = sum_x[COORD_BITS-1:0];
        if (sum_y < 0)
            clamp_y = '0;
        else if (sum_y >= $signed({1'b0, eff_h}))
            clamp_y = COORD_BITS'(eff_h - SW'(1));
        else
            clamp_y = sum_y[COORD_BITS-1:0];
        pkt_btn = r_header[BTN_W-1:0];
    end

    // packet framing
    always_comb begin
        is_ack = (r_phase != PH_XDELTA) && (r_phase != PH_YDELTA) && (i_rx_byte == ACK_BYTE);
        n_phase = r_phase;
        if (rx_fire) begin
            unique case (r_phase)
                PH_XDELTA: n_phase = PH_YDELTA;
                PH_YDELTA: n_phase = PH_HEAD;
                default:   n_phase = is_ack ? PH_HEAD : PH_XDELTA;
            endcase
        end
    end

    always_comb begin
        n_header   = r_header;
        n_xbyte    = r_xbyte;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_last_btn = r_last_btn;
        has_result = 1'b0;
        n_s1_kind  = EV_ACK;
        n_s1_x     = r_pos_x;
        n_s1_y     = r_pos_y;
        n_s1_btn   = r_last_btn;
        n_s1_chg   = '0;
        n_s1_w     = eff_w;
        unique case (r_phase)
            PH_XDELTA: begin
                n_xbyte = i_rx_byte;
            end
            PH_YDELTA: begin
                has_result = 1'b1;
                n_pos_x    = clamp_x;
                n_pos_y    = clamp_y;
                n_last_btn = pkt_btn;
                n_s1_kind  = EV_MOVE;
                n_s1_x     = clamp_x;
                n_s1_y     = clamp_y;
                n_s1_btn   = pkt_btn;
                n_s1_chg   = pkt_btn ^ r_last_btn;
            end
            default: begin
                if (is_ack)
                    has_result = 1'b1;
                else
                    n_header = i_rx_byte;
            end
        endcase
        n_s1_valid = s1_load ? (rx_fire && has_result) : r_s1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD;
            r_header   <= '0;
            r_xbyte    <= '0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_last_btn <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_s1_valid <= n_s1_valid;
            if (rx_fire) begin
                r_header   <= n_header;
                r_xbyte    <= n_xbyte;
                r_pos_x    <= n_pos_x;
                r_pos_y    <= n_pos_y;
                r_last_btn <= n_last_btn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_kind <= n_s1_kind;
            r_s1_x    <= n_s1_x;
            r_s1_y    <= n_s1_y;
            r_s1_btn  <= n_s1_btn;
            r_s1_chg  <= n_s1_chg;
            r_s1_w    <= n_s1_w;
        end
    end

    // pixel index and result register
    assign idx_full = PW'(r_s1_y) * PW'(r_s1_w) + PW'(r_s1_x);
    assign idx_ext  = {{IDX_W{1'b0}}, idx_full};
    assign x_ext    = {{OUT_COORD_W{1'b0}}, r_s1_x};
    assign y_ext    = {{OUT_COORD_W{1'b0}}, r_s1_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (!r_ev_valid || !i_ev_stall) begin
            r_ev_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_ev_kind <= r_s1_kind;
            r_ev_x    <= x_ext[OUT_COORD_W-1:0];
            r_ev_y    <= y_ext[OUT_COORD_W-1:0];
            r_ev_btn  <= r_s1_btn;
            r_ev_chg  <= r_s1_chg;
            r_ev_draw <= (r_s1_kind == EV_MOVE) && r_s1_btn[0];
            r_ev_idx  <= (r_s1_kind == EV_MOVE) ? idx_ext[IDX_W-1:0] : '0;
        end
    end

    assign o_ev_valid        = r_ev_valid;
    assign o_event_kind      = r_ev_kind;
    assign o_cursor_x        = r_ev_x;
    assign o_cursor_y        = r_ev_y;
    assign o_buttons         = r_ev_btn;
    assign o_buttons_changed = r_ev_chg;
    assign o_draw            = r_ev_draw;
    assign o_pixel_index     = r_ev_idx;

    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid && (o_event_kind == EV_ACK) |->
            (o_buttons_changed == '0) && !o_draw && (o_pixel_index == '0))
        else $error("acknowledge request carries movement data");

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_s1_kind == EV_MOVE) |->
            (SW'(r_s1_x) < r_s1_w) && (SW'(r_s1_y) < eff_h))
        else $error("cursor outside the screen after a packet");

    a_ack_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_fire && is_ack |=> $stable(r_pos_x) && $stable(r_pos_y) && $stable(r_last_btn))
        else $error("acknowledge byte changed the cursor state");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for ps2_mouse_packet_tracker_core: byte driver, event monitor,
// in-line packet predictor and APB screen-size writes between traffic phases.
// Depends on ps2mt_pkg and ps2_mouse_packet_tracker_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2mt_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int DELTA_WRAP    = 'h100;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 33;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASES        = 10;
    localparam int PHASE_BYTES   = 80;
    localparam int CALM_PHASE    = 3;

    typedef struct packed {
        logic                   kind;
        logic [OUT_COORD_W-1:0] x;
        logic [OUT_COORD_W-1:0] y;
        logic [BTN_W-1:0]       btn;
        logic [BTN_W-1:0]       chg;
        logic                   draw;
        logic [IDX_W-1:0]       idx;
    } t_event;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  rx_valid = 1'b0;
    logic                  rx_stall;
    logic [7:0]            rx_byte  = '0;
    logic                  ev_valid;
    logic                  ev_stall = 1'b0;
    logic                  ev_kind;
    logic [OUT_COORD_W-1:0] ev_x;
    logic [OUT_COORD_W-1:0] ev_y;
    logic [BTN_W-1:0]      ev_btn;
    logic [BTN_W-1:0]      ev_chg;
    logic                  ev_draw;
    logic [IDX_W-1:0]      ev_idx;

    logic [7:0] bytes_to_send[$];
    t_event     events_due[$];
    bit         jitter_on     = 1'b1;
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         gen_phase      = 0;
    int         bytes_queued   = 0;

    // packet tracker mirror
    t_phase                 frame_phase = PH_HEAD;
    logic [7:0]             head_byte   = '0;
    logic [7:0]             dx_byte     = '0;
    logic [OUT_COORD_W-1:0] cur_x       = '0;
    logic [OUT_COORD_W-1:0] cur_y       = '0;
    logic [BTN_W-1:0]       held_btn    = '0;
    logic [CFG_W-1:0]       width_reg   = WIDTH_RESET;
    logic [CFG_W-1:0]       height_reg  = HEIGHT_RESET;

    t_event seen_ev;
    t_event want_ev;
    string  bad_fields;

    ps2_mouse_packet_tracker_core #(.COORD_BITS(COORD_BITS)) u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_rx_valid        (rx_valid),
        .o_rx_stall        (rx_stall),
        .i_rx_byte         (rx_byte),
        .o_ev_valid        (ev_valid),
        .i_ev_stall        (ev_stall),
        .o_event_kind      (ev_kind),
        .o_cursor_x        (ev_x),
        .o_cursor_y        (ev_y),
        .o_buttons         (ev_btn),
        .o_buttons_changed (ev_chg),
        .o_draw            (ev_draw),
        .o_pixel_index     (ev_idx)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int screen_span(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > (1 << COORD_BITS)) return 1 << COORD_BITS;
        return int'(v);
    endfunction

    function automatic logic [OUT_COORD_W-1:0] clamp_to(int v, int size);
        if (v < 0) return '0;
        if (v >= size) return OUT_COORD_W'(size - 1);
        return OUT_COORD_W'(v);
    endfunction

    function automatic string show_event(t_event e);
        return $sformatf("kind=%0d x=%0d y=%0d btn=%0d chg=%0d draw=%0d idx=%0d",
                         e.kind, e.x, e.y, e.btn, e.chg, e.draw, e.idx);
    endfunction

    task automatic track_byte(input logic [7:0] b);
        int     w;
        int     h;
        int     dx;
        int     dy;
        t_event ev;
        ev = '0;
        case (frame_phase)
            PH_XDELTA: begin
                dx_byte     = b;
                frame_phase = PH_YDELTA;
            end
            PH_YDELTA: begin
                frame_phase = PH_HEAD;
                w  = screen_span(width_reg);
                h  = screen_span(height_reg);
                dx = int'(dx_byte) - (head_byte[X_SIGN_BIT] ? DELTA_WRAP : 0);
                dy = int'(b) - (head_byte[Y_SIGN_BIT] ? DELTA_WRAP : 0);
                cur_x = clamp_to(int'(cur_x) + dx, w);
                cur_y = clamp_to(int'(cur_y) - dy, h);
                ev.kind = EV_MOVE;
                ev.x    = cur_x;
                ev.y    = cur_y;
                ev.btn  = head_byte[BTN_W-1:0];
                ev.chg  = head_byte[BTN_W-1:0] ^ held_btn;
                ev.draw = head_byte[0];
                ev.idx  = IDX_W'(longint'(cur_y) * w + longint'(cur_x));
                held_btn = head_byte[BTN_W-1:0];
                events_due.push_back(ev);
            end
            default: begin
                if (b == ACK_BYTE) begin
                    ev.kind = EV_ACK;
                    ev.x    = cur_x;
                    ev.y    = cur_y;
                    ev.btn  = held_btn;
                    events_due.push_back(ev);
                end else begin
                    head_byte   = b;
                    frame_phase = PH_XDELTA;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, t_event want, t_event got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s\n  expected %s\n  actual   %s",
                     $time, what, show_event(want), show_event(got));
        end
    endtask

    // byte driver
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else begin
            if (rx_valid && !rx_stall) track_byte(rx_byte);
            if (!rx_valid || !rx_stall) begin
                if (bytes_to_send.size() != 0 &&
                    !(jitter_on && $urandom_range(99) < IDLE_PCT)) begin
                    rx_valid <= 1'b1;
                    rx_byte  <= bytes_to_send.pop_front();
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // event monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            ev_stall <= 1'b0;
        end else begin
            if (ev_valid && !ev_stall) begin
                seen_ev = '{ev_kind, ev_x, ev_y, ev_btn, ev_chg, ev_draw, ev_idx};
                if (events_due.size() == 0) begin
                    report_mismatch("event with nothing pending", '0, seen_ev);
                end else begin
                    want_ev = events_due.pop_front();
                    bad_fields = "";
                    if (seen_ev.kind !== want_ev.kind) bad_fields = {bad_fields, " event_kind"};
                    if (seen_ev.x !== want_ev.x) bad_fields = {bad_fields, " cursor_x"};
                    if (seen_ev.y !== want_ev.y) bad_fields = {bad_fields, " cursor_y"};
                    if (seen_ev.btn !== want_ev.btn) bad_fields = {bad_fields, " buttons"};
                    if (seen_ev.chg !== want_ev.chg) bad_fields = {bad_fields, " buttons_changed"};
                    if (seen_ev.draw !== want_ev.draw) bad_fields = {bad_fields, " draw"};
                    if (seen_ev.idx !== want_ev.idx) bad_fields = {bad_fields, " pixel_index"};
                    if (bad_fields != "") begin
                        report_mismatch({"event mismatch in", bad_fields}, want_ev, seen_ev);
                    end
                end
            end
            ev_stall <= jitter_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("ps2_mouse_packet_tracker_core verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        bytes_to_send.push_back(b);
        bytes_queued++;
        if (gen_phase == 0 && b == ACK_BYTE) gen_phase = 0;
        else gen_phase = (gen_phase + 1) % 3;
    endtask

    function automatic int pick_delta(int drift);
        case ($urandom_range(3))
            0:       return int'($urandom_range(511)) - DELTA_WRAP;
            1:       return int'($urandom_range(16)) - 8;
            default: return drift * int'($urandom_range(255, 64));
        endcase
    endfunction

    // screen-space drift: dy is inverted on screen
    task automatic send_packet(int drift_x, int drift_y);
        int         dx;
        int         dy;
        logic [7:0] head;
        dx   = pick_delta(drift_x);
        dy   = pick_delta(-drift_y);
        head = 8'($urandom_range(255));
        head[X_SIGN_BIT] = dx < 0;
        head[Y_SIGN_BIT] = dy < 0;
        while (gen_phase != 0) send_byte(8'($urandom_range(255)));
        send_byte(head);
        send_byte(8'(dx));
        send_byte(8'(dy));
    endtask

    task automatic write_screen_reg(input logic which, input int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({which, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_SCREEN_WIDTH) width_reg = CFG_W'(value);
        else height_reg = CFG_W'(value);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (bytes_to_send.size() != 0 || rx_valid || events_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        int         cfg_w[8];
        int         cfg_h[8];
        logic [7:0] opening[$];
        int         drift_x;
        int         drift_y;
        int         target;
        int         roll;

        cfg_w   = '{4096, 1, 0, 8191, 4097, 13, 4096, 1};
        cfg_h   = '{4096, 1, 0, 8191, 300, 7, 1, 4096};
        opening = '{
            ACK_BYTE,
            8'h09, 8'h7F, 8'h00,
            8'h3F, 8'h80, 8'h80,
            8'h08, ACK_BYTE, ACK_BYTE,
            8'hFF, 8'hFF, 8'hFF,
            8'h00, 8'h00, 8'h00,
            8'h10, 8'h00, 8'h00,
            8'h20, 8'h00, 8'h00,
            8'h0C, 8'hFF, 8'h01,
            ACK_BYTE
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        foreach (opening[i]) send_byte(opening[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            if (ph < 8) begin
                write_screen_reg(REG_SCREEN_WIDTH, cfg_w[ph]);
                write_screen_reg(REG_SCREEN_HEIGHT, cfg_h[ph]);
            end else begin
                write_screen_reg(REG_SCREEN_WIDTH, int'($urandom_range(4096, 1)));
                write_screen_reg(REG_SCREEN_HEIGHT, int'($urandom_range(8191)));
            end
            drift_x   = int'($urandom_range(2)) - 1;
            drift_y   = int'($urandom_range(2)) - 1;
            jitter_on = (ph != CALM_PHASE);
            @(negedge clk);
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target) begin
                roll = int'($urandom_range(99));
                if (roll < 78) begin
                    send_packet(drift_x, drift_y);
                end else if (roll < 88) begin
                    send_byte(ACK_BYTE);
                end else begin
                    repeat ($urandom_range(2, 1)) send_byte(8'($urandom_range(255)));
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0 && events_due.size() == 0) begin
            $display("ps2_mouse_packet_tracker_core verification clean");
        end else begin
            $display("ps2_mouse_packet_tracker_core verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ps2mt_pkg.sv
design/ps2_mouse_packet_tracker_core.sv
dv/tb_top.sv
